// File: src/stft_pkg.sv
`default_nettype none
package stft_pkg;

  localparam int WINDOW      = 64;
  localparam int LOG_W       = 6;
  localparam int HANN_DEN    = WINDOW - 1;
  localparam int SAMPLE_BITS = 16;
  localparam int OUT_BITS    = 24;
  localparam int HOP_BITS    = 7;
  localparam logic [HOP_BITS-1:0] HOP_RESET = 7'd32;
  localparam int QDEPTH      = 2;

  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam longint          ONE_Q30     = 64'sd1073741824;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          last_sample;
  } in_word_t;

  typedef struct packed {
    logic        [LOG_W-1:0]    bin_index;
    logic signed [OUT_BITS-1:0] bin_real;
    logic signed [OUT_BITS-1:0] bin_imag;
    logic                       last_bin;
  } out_word_t;

  typedef struct packed {
    logic [LOG_W-1:0] start;
  } frame_cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_CP_RD, ST_CP_MUL, ST_CP_WR,
    ST_BF_RD, ST_BF_MUL, ST_BF_WR_P, ST_BF_WR_Q,
    ST_OUT_RD, ST_OUT_SHOW
  } back_state_t;

  typedef logic [WINDOW-1:0][15:0] tab_t;

  // half away from zero, 15 fractional bits dropped
  function automatic logic signed [47:0] rnd15(input logic signed [47:0] v);
    logic signed [47:0] half;
    half = 48'sd16384;
    if (v >= 0) return (v + half) >>> 15;
    return -((-v + half) >>> 15);
  endfunction

  function automatic logic signed [OUT_BITS-1:0] sat_out(input logic signed [47:0] v);
    logic signed [47:0] hi, lo;
    hi = 48'sd8388607;
    lo = -48'sd8388608;
    if (v > hi) return OUT_BITS'(hi);
    if (v < lo) return OUT_BITS'(lo);
    return OUT_BITS'(v);
  endfunction

  function automatic logic [LOG_W-1:0] bitrev(input logic [LOG_W-1:0] v);
    logic [LOG_W-1:0] r;
    for (int i = 0; i < LOG_W; i++) r[i] = v[LOG_W-1-i];
    return r;
  endfunction

  // elaboration-time helpers for the constant tables
  function automatic longint rnd15_l(input longint v);
    if (v >= 0) return (v + 64'sd16384) >>> 15;
    return -((-v + 64'sd16384) >>> 15);
  endfunction

  function automatic longint sat16_l(input longint v);
    if (v > 64'sd32767) return 64'sd32767;
    if (v < -64'sd32768) return -64'sd32768;
    return v;
  endfunction

  // returns {sin, cos} in Q30
  function automatic logic [127:0] trig_q30(input longint unsigned x, input int unsigned q);
    longint unsigned x2, term;
    longint s, c;
    x2 = (x * x) >> 30;
    s = longint'(x);
    c = ONE_Q30;
    term = x;
    term = ((term * x2) >> 30) / 6;   s = s - longint'(term);
    term = ((term * x2) >> 30) / 20;  s = s + longint'(term);
    term = ((term * x2) >> 30) / 42;  s = s - longint'(term);
    term = ((term * x2) >> 30) / 72;  s = s + longint'(term);
    term = ((term * x2) >> 30) / 110; s = s - longint'(term);
    term = ((term * x2) >> 30) / 156; s = s + longint'(term);
    term = ((term * x2) >> 30) / 210; s = s - longint'(term);
    term = ((term * x2) >> 30) / 272; s = s + longint'(term);
    term = ((term * x2) >> 30) / 342; s = s - longint'(term);
    term = longint'(ONE_Q30);
    term = ((term * x2) >> 30) / 2;   c = c - longint'(term);
    term = ((term * x2) >> 30) / 12;  c = c + longint'(term);
    term = ((term * x2) >> 30) / 30;  c = c - longint'(term);
    term = ((term * x2) >> 30) / 56;  c = c + longint'(term);
    term = ((term * x2) >> 30) / 90;  c = c - longint'(term);
    term = ((term * x2) >> 30) / 132; c = c + longint'(term);
    term = ((term * x2) >> 30) / 182; c = c - longint'(term);
    term = ((term * x2) >> 30) / 240; c = c + longint'(term);
    term = ((term * x2) >> 30) / 306; c = c - longint'(term);
    case (q & 3)
      0: return {s, c};
      1: return {c, -s};
      2: return {-s, -c};
      default: return {-c, s};
    endcase
  endfunction

  function automatic tab_t build_hann();
    tab_t t;
    int unsigned r, tt, q, f;
    logic [127:0] sc;
    longint c;
    for (int n = 0; n < WINDOW; n++) begin
      r  = n % HANN_DEN;
      tt = 4 * r;
      q  = tt / HANN_DEN;
      f  = tt - q * HANN_DEN;
      sc = trig_q30(HALF_PI_Q30 * longint'(f) / HANN_DEN, q);
      c  = longint'(sc[63:0]);
      t[n] = 16'(sat16_l(rnd15_l((ONE_Q30 - c) / 2)));
    end
    return t;
  endfunction

  function automatic tab_t build_tw(input logic want_sin);
    tab_t t;
    int unsigned tt, q, f;
    logic [127:0] sc;
    for (int n = 0; n < WINDOW; n++) begin
      tt = 4 * n;
      q  = tt / WINDOW;
      f  = tt - q * WINDOW;
      sc = trig_q30(HALF_PI_Q30 * longint'(f) / WINDOW, q);
      if (want_sin) t[n] = 16'(sat16_l(rnd15_l(longint'(sc[127:64]))));
      else          t[n] = 16'(sat16_l(rnd15_l(longint'(sc[63:0]))));
    end
    return t;
  endfunction

  localparam tab_t HANN_TAB = build_hann();
  localparam tab_t TW_COS   = build_tw(1'b0);
  localparam tab_t TW_SIN   = build_tw(1'b1);

endpackage
`default_nettype wire

// File: src/stft_hann_radix2_frames_core.sv
`default_nettype none
// Hann-windowed 64-point STFT engine.
// in_*  : one sample word per handshake (valid/ready), sample plus last_sample.
// cfg_* : write of the hop register (7 bits, resets to 32); write only while idle.
// out_* : one bin word per handshake: index, real, imag, last_bin on bin 63.
// The first frame fires on the 64th sample of a record, then every hop samples;
// hop 0 acts as 1 and a hop above 64 as 64. A frame is windowed and copied
// into the work RAM (read, multiply, write per sample), then runs the FFT on
// the one shared butterfly unit (read, multiply, write p, write q per butterfly),
// then reads and shows each bin in turn.
// in_ready drops only while a frame waits in the queue or is being copied;
// samples that do not trigger a frame are taken one per cycle otherwise,
// including while the FFT runs or bins wait on a stalled receiver.
// A stalled receiver holds the current bin word; the FFT back end waits.
// Reset (rst_n low, synchronous) clears the counters, the queue and the
// sequencer; the sample and work RAMs need no clearing.
module stft_hann_radix2_frames_core
  import stft_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire in_word_t            in_data,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [HOP_BITS-1:0] cfg_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output out_word_t                out_data
);

  logic                   q_empty, copy_busy, push, pop;
  frame_cmd_t             push_cmd, q_head;
  logic [LOG_W-1:0]       rd_addr;
  logic [SAMPLE_BITS-1:0] rd_data;

  assign cfg_ready = 1'b1;

  stft_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_data, .cfg_valid, .cfg_data,
    .q_empty, .copy_busy, .push, .push_cmd, .rd_addr, .rd_data
  );

  stft_fifo u_fifo (
    .clk, .rst_n, .push, .push_cmd, .pop, .head(q_head), .empty(q_empty)
  );

  stft_back u_back (
    .clk, .rst_n, .q_empty, .q_head, .pop, .copy_busy, .rd_addr, .rd_data,
    .out_valid, .out_ready, .out_data
  );

endmodule
`default_nettype wire

// File: src/stft_front.sv
`default_nettype none
module stft_front
  import stft_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire in_word_t              in_data,
  input  wire logic                  cfg_valid,
  input  wire logic [HOP_BITS-1:0]   cfg_data,
  input  wire logic                  q_empty,
  input  wire logic                  copy_busy,
  output logic                       push,
  output frame_cmd_t                 push_cmd,
  input  wire logic [LOG_W-1:0]      rd_addr,
  output logic [SAMPLE_BITS-1:0]     rd_data
);

  logic [SAMPLE_BITS-1:0] mem [WINDOW];
  logic [HOP_BITS-1:0] hop_r;
  logic [LOG_W:0]      fill_r, fill_nxt;
  logic [LOG_W-1:0]    cd_r, cd_nxt;
  logic [LOG_W-1:0]    wptr_r;
  logic [LOG_W-1:0]    h_m1;
  logic                acc, emit;

  assign in_ready = q_empty && !copy_busy;
  assign acc      = in_valid && in_ready;

  always_comb begin
    if (hop_r == '0)                    h_m1 = '0;
    else if (hop_r > HOP_BITS'(WINDOW)) h_m1 = LOG_W'(WINDOW - 1);
    else                                h_m1 = LOG_W'(hop_r - 1'b1);
  end

  always_comb begin
    emit     = 1'b0;
    fill_nxt = fill_r;
    cd_nxt   = cd_r;
    if (fill_r < (LOG_W+1)'(WINDOW)) begin
      fill_nxt = fill_r + 1'b1;
      if (fill_nxt == (LOG_W+1)'(WINDOW)) begin
        emit   = 1'b1;
        cd_nxt = h_m1;
      end
    end else if (cd_r == '0) begin
      emit   = 1'b1;
      cd_nxt = h_m1;
    end else begin
      cd_nxt = cd_r - 1'b1;
    end
    if (in_data.last_sample) begin
      fill_nxt = '0;
      cd_nxt   = '0;
    end
  end

  assign push           = acc && emit;
  assign push_cmd.start = wptr_r + 1'b1;  // oldest sample once this one is in

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hop_r  <= HOP_RESET;
      fill_r <= '0;
      cd_r   <= '0;
      wptr_r <= '0;
    end else begin
      if (cfg_valid) hop_r <= cfg_data;
      if (acc) begin
        fill_r <= fill_nxt;
        cd_r   <= cd_nxt;
        wptr_r <= wptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) mem[wptr_r] <= in_data.sample;
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

// File: src/stft_fifo.sv
`default_nettype none
module stft_fifo
  import stft_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       push,
  input  wire frame_cmd_t push_cmd,
  input  wire logic       pop,
  output frame_cmd_t      head,
  output logic            empty
);

  frame_cmd_t      ent_r [QDEPTH];
  logic            rd_r, wr_r;
  logic [1:0]      cnt_r;

  assign empty = (cnt_r == '0);
  assign head  = ent_r[rd_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_r  <= 1'b0;
      wr_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (push) wr_r <= !wr_r;
      if (pop)  rd_r <= !rd_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) ent_r[wr_r] <= push_cmd;
  end

endmodule
`default_nettype wire

// File: src/stft_back.sv
`default_nettype none
module stft_back
  import stft_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   q_empty,
  input  wire frame_cmd_t             q_head,
  output logic                        pop,
  output logic                        copy_busy,
  output logic [LOG_W-1:0]            rd_addr,
  input  wire logic [SAMPLE_BITS-1:0] rd_data,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output out_word_t                   out_data
);

  back_state_t state_r, state_nxt;
  logic [LOG_W-1:0]   k_r, k_nxt, start_r;
  logic [2:0]         s_r, s_nxt;
  logic [LOG_W-2:0]   b_r, b_nxt;

  logic [2*OUT_BITS-1:0] mem [WINDOW];
  logic [2*OUT_BITS-1:0] rd_a_r, rd_b_r;
  logic [LOG_W-1:0]      ra_a, ra_b, wa;
  logic [2*OUT_BITS-1:0] wd;
  logic                  we;

  logic signed [31:0] prod_r;
  logic signed [39:0] cbr_r, sbi_r, cbi_r, sbr_r;
  logic [2*OUT_BITS-1:0] qres_r;

  logic [LOG_W-1:0] half, lowm, bx, p, q;
  logic [LOG_W-1:0] ti;
  logic signed [OUT_BITS-1:0] ar, ai, br, bi;
  logic signed [47:0] tr, tim;
  logic signed [OUT_BITS-1:0] pr, pi, qr, qi, wre;

  // butterfly addressing for stage s, butterfly b
  always_comb begin
    half = LOG_W'(1) << s_r;
    lowm = half - 1'b1;
    bx   = {1'b0, b_r};
    p    = ((bx >> s_r) << (s_r + 3'd1)) | (bx & lowm);
    q    = p | half;
    ti   = LOG_W'((bx & lowm) << (3'(LOG_W - 1) - s_r));
  end

  assign ar = rd_a_r[2*OUT_BITS-1:OUT_BITS];
  assign ai = rd_a_r[OUT_BITS-1:0];
  assign br = rd_b_r[2*OUT_BITS-1:OUT_BITS];
  assign bi = rd_b_r[OUT_BITS-1:0];

  always_comb begin
    tr  = rnd15(48'(cbr_r) + 48'(sbi_r));
    tim = rnd15(48'(cbi_r) - 48'(sbr_r));
    pr  = sat_out(48'(ar) + tr);
    pi  = sat_out(48'(ai) + tim);
    qr  = sat_out(48'(ar) - tr);
    qi  = sat_out(48'(ai) - tim);
    wre = OUT_BITS'(rnd15(48'(prod_r)));
  end

  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    s_nxt     = s_r;
    b_nxt     = b_r;
    pop       = 1'b0;
    we        = 1'b0;
    wa        = p;
    wd        = {pr, pi};
    out_valid = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          pop       = 1'b1;
          k_nxt     = '0;
          state_nxt = ST_CP_RD;
        end
      end
      ST_CP_RD:  state_nxt = ST_CP_MUL;
      ST_CP_MUL: state_nxt = ST_CP_WR;
      ST_CP_WR: begin
        we = 1'b1;
        wa = bitrev(k_r);
        wd = {wre, {OUT_BITS{1'b0}}};
        k_nxt = k_r + 1'b1;
        if (k_r == LOG_W'(WINDOW - 1)) begin
          s_nxt     = '0;
          b_nxt     = '0;
          state_nxt = ST_BF_RD;
        end else begin
          state_nxt = ST_CP_RD;
        end
      end
      ST_BF_RD:  state_nxt = ST_BF_MUL;
      ST_BF_MUL: state_nxt = ST_BF_WR_P;
      ST_BF_WR_P: begin
        we = 1'b1;
        state_nxt = ST_BF_WR_Q;
      end
      ST_BF_WR_Q: begin
        we = 1'b1;
        wa = q;
        wd = qres_r;
        b_nxt = b_r + 1'b1;
        state_nxt = ST_BF_RD;
        if (b_r == (LOG_W-1)'(WINDOW/2 - 1)) begin
          b_nxt = '0;
          if (s_r == 3'(LOG_W - 1)) begin
            k_nxt     = '0;
            state_nxt = ST_OUT_RD;
          end else begin
            s_nxt = s_r + 1'b1;
          end
        end
      end
      ST_OUT_RD: state_nxt = ST_OUT_SHOW;
      ST_OUT_SHOW: begin
        out_valid = 1'b1;
        if (out_ready) begin
          k_nxt = k_r + 1'b1;
          state_nxt = (k_r == LOG_W'(WINDOW - 1)) ? ST_IDLE : ST_OUT_RD;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign copy_busy = (state_r == ST_CP_RD) || (state_r == ST_CP_MUL) || (state_r == ST_CP_WR);
  assign rd_addr   = start_r + k_r;
  assign ra_a      = (state_r == ST_OUT_RD || state_r == ST_OUT_SHOW) ? k_r : p;
  assign ra_b      = q;

  assign out_data.bin_index = k_r;
  assign out_data.bin_real  = rd_a_r[2*OUT_BITS-1:OUT_BITS];
  assign out_data.bin_imag  = rd_a_r[OUT_BITS-1:0];
  assign out_data.last_bin  = (k_r == LOG_W'(WINDOW - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      k_r     <= '0;
      s_r     <= '0;
      b_r     <= '0;
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
      s_r     <= s_nxt;
      b_r     <= b_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) start_r <= q_head.start;
    if (state_r == ST_CP_MUL)
      prod_r <= $signed(rd_data) * $signed(HANN_TAB[k_r]);
    if (state_r == ST_BF_MUL) begin
      cbr_r <= $signed(TW_COS[ti]) * br;
      sbi_r <= $signed(TW_SIN[ti]) * bi;
      cbi_r <= $signed(TW_COS[ti]) * bi;
      sbr_r <= $signed(TW_SIN[ti]) * br;
    end
    if (state_r == ST_BF_WR_P) qres_r <= {qr, qi};
  end

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    rd_a_r <= mem[ra_a];
    rd_b_r <= mem[ra_b];
  end

endmodule
`default_nettype wire

// File: src/stft_checker.sv
`default_nettype none
module stft_checker
  import stft_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      out_valid,
  input wire logic      out_ready,
  input wire out_word_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("out word changed while stalled");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("out_valid after reset");

  a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.last_bin == (out_data.bin_index == LOG_W'(WINDOW - 1))))
    else $error("last_bin does not match bin index");

  a_bin_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_data.last_bin |=> !out_valid)
    else $error("bin word without read cycle");

endmodule

bind stft_hann_radix2_frames_core stft_checker u_chk (.*);
`default_nettype wire

// File: bench/stft_hann_radix2_frames_core_test.sv
`timescale 1ns / 1ps
module stft_hann_radix2_frames_core_test;
  import stft_pkg::*;

  localparam int   N_PTS        = 64;
  localparam int   DRAIN_CYCLES = 1400;
  localparam int   HOLD_CYCLES  = 4000;
  localparam int   LIMIT        = 1500000;
  localparam longint unsigned QUARTER_TURN_Q30 = 64'd1686629713;
  localparam longint          UNIT_Q30         = 64'sd1073741824;

  class bin_scoreboard;
    out_word_t   bins_due[$];
    longint      hann[N_PTS];
    longint      tw_c[N_PTS];
    longint      tw_s[N_PTS];
    longint      window_buf[N_PTS];
    int unsigned filled;
    int unsigned countdown;
    int unsigned hop_reg;
    int          errors;

    function new();
      longint s, c;
      for (int n = 0; n < N_PTS; n++) begin
        turn(n, N_PTS - 1, s, c);
        hann[n] = sat(rnd15((UNIT_Q30 - c) / 2), 16);
        turn(n, N_PTS, s, c);
        tw_c[n] = sat(rnd15(c), 16);
        tw_s[n] = sat(rnd15(s), 16);
      end
      filled    = 0;
      countdown = 0;
      hop_reg   = 32;
      errors    = 0;
    endfunction

    static function longint rnd15(longint v);
      if (v >= 0) return (v + 16384) >>> 15;
      return -((-v + 16384) >>> 15);
    endfunction

    static function longint sat(longint v, int bits);
      longint lim;
      lim = longint'(1) << (bits - 1);
      if (v > lim - 1) return lim - 1;
      if (v < -lim) return -lim;
      return v;
    endfunction

    // sin/cos of one turn fraction num/den, Q30, Taylor series on the quadrant
    static function void turn(int unsigned num, int unsigned den,
                              output longint s_o, output longint c_o);
      int unsigned r, t, q, f;
      longint unsigned x, x2, term;
      longint s, c;
      r = num % den;
      t = 4 * r;
      q = t / den;
      f = t - q * den;
      x = QUARTER_TURN_Q30 * longint'(f) / den;
      x2 = (x * x) >> 30;
      term = x;
      s = longint'(x);
      c = UNIT_Q30;
      for (int k = 1; k <= 9; k++) begin
        term = ((term * x2) >> 30) / longint'((2 * k) * (2 * k + 1));
        s = (k & 1) ? s - longint'(term) : s + longint'(term);
      end
      term = UNIT_Q30;
      for (int k = 1; k <= 9; k++) begin
        term = ((term * x2) >> 30) / longint'((2 * k - 1) * (2 * k));
        c = (k & 1) ? c - longint'(term) : c + longint'(term);
      end
      case (q & 3)
        0: begin s_o = s;  c_o = c;  end
        1: begin s_o = c;  c_o = -s; end
        2: begin s_o = -s; c_o = -c; end
        default: begin s_o = -c; c_o = s; end
      endcase
    endfunction

    function void spectrum();
      longint re[N_PTS], im[N_PTS];
      longint tr, ti, ar, ai, br, bi, cw, sw;
      int unsigned j, bt, p, q, stp;
      out_word_t w;
      for (int k = 0; k < N_PTS; k++) begin
        re[k] = rnd15(window_buf[k] * hann[k]);
        im[k] = 0;
      end
      j = 0;
      for (int i = 1; i < N_PTS; i++) begin
        bt = N_PTS >> 1;
        while (j & bt) begin
          j ^= bt;
          bt >>= 1;
        end
        j |= bt;
        if (i < j) begin
          tr = re[i]; ti = im[i];
          re[i] = re[j]; im[i] = im[j];
          re[j] = tr; im[j] = ti;
        end
      end
      for (int half = 1; half < N_PTS; half <<= 1) begin
        stp = N_PTS / (2 * half);
        for (int st = 0; st < N_PTS; st += 2 * half) begin
          for (int a = 0; a < half; a++) begin
            p = st + a;
            q = p + half;
            cw = tw_c[(a * stp) % N_PTS];
            sw = tw_s[(a * stp) % N_PTS];
            br = re[q]; bi = im[q];
            tr = rnd15(cw * br + sw * bi);
            ti = rnd15(cw * bi - sw * br);
            ar = re[p]; ai = im[p];
            re[q] = sat(ar - tr, OUT_BITS);
            im[q] = sat(ai - ti, OUT_BITS);
            re[p] = sat(ar + tr, OUT_BITS);
            im[p] = sat(ai + ti, OUT_BITS);
          end
        end
      end
      for (int k = 0; k < N_PTS; k++) begin
        w.bin_index = k[LOG_W-1:0];
        w.bin_real  = re[k][OUT_BITS-1:0];
        w.bin_imag  = im[k][OUT_BITS-1:0];
        w.last_bin  = (k == N_PTS - 1);
        bins_due.push_back(w);
      end
    endfunction

    function void note_sample(in_word_t w);
      int unsigned h;
      bit fire;
      fire = 0;
      h = (hop_reg == 0) ? 1 : ((hop_reg > 64) ? 64 : hop_reg);
      if (filled < N_PTS) begin
        window_buf[filled] = longint'(w.sample);
        filled++;
        if (filled == N_PTS) begin
          fire = 1;
          countdown = (h - 1) & 63;
        end
      end else begin
        for (int i = 0; i < N_PTS - 1; i++) window_buf[i] = window_buf[i+1];
        window_buf[N_PTS-1] = longint'(w.sample);
        if (countdown == 0) begin
          fire = 1;
          countdown = (h - 1) & 63;
        end else begin
          countdown--;
        end
      end
      if (w.last_sample) begin
        filled = 0;
        countdown = 0;
      end
      if (fire) spectrum();
    endfunction

    task report(string msg);
      $display("ERROR @%0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_bin(out_word_t got);
      out_word_t want;
      if (bins_due.size() == 0) begin
        report($sformatf("unexpected bin word, index %0d", got.bin_index));
        return;
      end
      want = bins_due.pop_front();
      if (got.bin_index !== want.bin_index)
        report($sformatf("bin_index got %0d want %0d", got.bin_index, want.bin_index));
      if (got.bin_real !== want.bin_real)
        report($sformatf("bin %0d real got %0d want %0d", want.bin_index,
                         got.bin_real, want.bin_real));
      if (got.bin_imag !== want.bin_imag)
        report($sformatf("bin %0d imag got %0d want %0d", want.bin_index,
                         got.bin_imag, want.bin_imag));
      if (got.last_bin !== want.last_bin)
        report($sformatf("bin %0d last_bin got %0b want %0b", want.bin_index,
                         got.last_bin, want.last_bin));
    endtask
  endclass

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  in_word_t            in_data;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [HOP_BITS-1:0] cfg_data;
  logic                out_valid;
  logic                out_ready;
  out_word_t           out_data;

  bin_scoreboard sb = new();
  bit            hold_req;
  bit            no_idle;
  int            cycles = 0;

  stft_hann_radix2_frames_core DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) sb.hop_reg = cfg_data;
      if (in_valid && in_ready) sb.note_sample(in_data);
      if (out_valid && out_ready) sb.check_bin(out_data);
    end
  end

  // receiver: random stalls per word, one long hold-off on request
  initial begin
    int n;
    out_ready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 0;
      end
      n = no_idle ? 0 : $urandom_range(0, 6);
      if (n > 0) begin
        out_ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  task automatic send(input logic signed [15:0] s, input logic last);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data.sample <= s;
    in_data.last_sample <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.bins_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_hop(input logic [HOP_BITS-1:0] v);
    settle();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic signed [15:0] pick_sample();
    case ($urandom_range(0, 9))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      default: return 16'($urandom);
    endcase
  endfunction

  // one record of random samples, last word flagged
  task automatic play_record(input int len);
    for (int i = 1; i <= len; i++) send(pick_sample(), i == len);
  endtask

  initial begin
    logic signed [15:0] edge_vals[8];
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    hold_req  = 0;
    no_idle   = 0;
    edge_vals = '{16'sh7fff, 16'sh8000, 16'sh0000, 16'shffff,
                  16'sh0001, 16'sh5555, 16'shaaaa, 16'sh7ffe};
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // short record with extreme values: no frame
    for (int i = 0; i < 8; i++) send(edge_vals[i], i == 7);
    // full-scale constant record, last word lands on the frame trigger
    for (int i = 1; i <= N_PTS; i++) send(16'sh7fff, i == N_PTS);

    // hop 1 with the receiver held off: input must back up
    write_hop(7'd1);
    hold_req = 1;
    play_record(68);

    write_hop(7'd127);
    play_record(66);

    write_hop(7'd0);
    play_record(66);
    // broken records: random early ends
    for (int i = 0; i < 20; i++) send(pick_sample(), $urandom_range(0, 4) == 0);
    send(pick_sample(), 1'b1);

    write_hop(7'd5);
    no_idle = 1;
    play_record(70);
    no_idle = 0;

    settle();
    if (sb.errors == 0 && sb.bins_due.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// File: stft_hann_radix2_frames_core.f
src/stft_pkg.sv
src/stft_front.sv
src/stft_fifo.sv
src/stft_back.sv
src/stft_hann_radix2_frames_core.sv
src/stft_checker.sv
bench/stft_hann_radix2_frames_core_test.sv
